[hdl/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared sizes, codes and controller/datapath link types of the text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int HISTORY_LINES = 256;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int HEAD_W = $clog2(HISTORY_LINES);
  localparam int OFF_W  = $clog2(HISTORY_LINES + 1);
  localparam int SUM_W  = ((OFF_W > 8) ? OFF_W : 8) + 1;
  localparam int SCR_AW = $clog2(ROWS * COLUMNS);
  localparam int HIS_AW = $clog2(HISTORY_LINES * COLUMNS);

  // port field widths
  localparam int OP_W       = 3;
  localparam int CHAR_W     = 8;
  localparam int CNT_W      = 8;
  localparam int CROW_W     = 5;
  localparam int CCOL_W     = 7;
  localparam int VOFF_W     = 9;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
  localparam logic [OP_W-1:0] OP_UP    = 3'd1;
  localparam logic [OP_W-1:0] OP_DOWN  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR = 2'd1;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

  typedef enum logic [2:0] {
    CC_LF, CC_CR, CC_BS, CC_TAB, CC_PRINT, CC_IGNORE
  } chr_class_t;

  typedef enum logic [1:0] {
    RS_ZERO, RS_BLANK, RS_SCREEN, RS_HIST
  } rd_src_t;

  typedef struct packed {
    logic cap;
    logic exec;
    logic tab_wr;
    logic put_wr;
    logic adv;
    logic cmt_step;
    logic cmt_end;
    logic clr_step;
    logic clr_end;
    logic init;
    logic rd_issue;
    logic rd_take;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    chr_class_t      cls;
    logic            tab_more;
    logic            wrap;
    logic            last_row;
    logic            cmt_last;
    logic            clr_last;
  } tcw_sts_t;

endpackage

[hdl/tcw_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console: operation beats and result beats.
// ----------------------------------------------------------------------------
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;
  logic [CNT_W-1:0]  line_count;
  logic [CROW_W-1:0] cell_row;
  logic [CCOL_W-1:0] cell_column;

  modport source (output valid, operation, char_code, line_count, cell_row, cell_column,
                  input ready);
  modport sink (input valid, operation, char_code, line_count, cell_row, cell_column,
                output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CROW_W-1:0] cursor_row;
  logic [CCOL_W-1:0] cursor_column;
  logic [VOFF_W-1:0] view_offset;
  logic              cursor_shown;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, cursor_row, cursor_column, view_offset, cursor_shown,
                  cell_data, input ready);
  modport sink (input valid, cursor_row, cursor_column, view_offset, cursor_shown,
                cell_data, output ready);
endinterface

[hdl/tcw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console: steps one operation through the datapath.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  tcw_sts_t sts,
  output tcw_cmd_t cmd
);

  typedef enum logic [11:0] {
    ST_INIT = 12'b000000000001,
    ST_IDLE = 12'b000000000010,
    ST_EXEC = 12'b000000000100,
    ST_TAB  = 12'b000000001000,
    ST_PUT  = 12'b000000010000,
    ST_ADV  = 12'b000000100000,
    ST_CMT  = 12'b000001000000,
    ST_CLR  = 12'b000010000000,
    ST_RD1  = 12'b000100000000,
    ST_RD2  = 12'b001000000000,
    ST_DONE = 12'b010000000000,
    ST_SPR  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        cmd.init     = 1'b1;
        if (sts.clr_last) begin
          cmd.clr_end = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.op)
          OP_PUT: begin
            case (sts.cls)
              CC_LF:    state_nxt = ST_ADV;
              CC_TAB:   state_nxt = ST_TAB;
              CC_PRINT: state_nxt = ST_PUT;
              default:  state_nxt = ST_DONE;
            endcase
          end
          OP_READ:  state_nxt = ST_RD1;
          OP_CLEAR: state_nxt = ST_CLR;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_TAB: begin
        if (sts.tab_more) begin
          cmd.tab_wr = 1'b1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PUT: begin
        cmd.put_wr = 1'b1;
        state_nxt  = sts.wrap ? ST_ADV : ST_DONE;
      end
      ST_ADV: begin
        if (sts.last_row) begin
          state_nxt = ST_CMT;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_CMT: begin
        cmd.cmt_step = 1'b1;
        if (sts.cmt_last) begin
          cmd.cmt_end = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.clr_end = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_RD1: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_take = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/tcw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_dp
// Console datapath: screen ring, history ring, cursor, view offset, results.
// ----------------------------------------------------------------------------
module tcw_dp import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcw_cmd_t              cmd,
  output tcw_sts_t              sts,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [CNT_W-1:0]      in_line_count,
  input  logic [CROW_W-1:0]     in_cell_row,
  input  logic [CCOL_W-1:0]     in_cell_column,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [CROW_W-1:0]     out_cursor_row,
  output logic [CCOL_W-1:0]     out_cursor_column,
  output logic [VOFF_W-1:0]     out_view_offset,
  output logic                  out_cursor_shown,
  output logic [CELL_W-1:0]     out_cell_data
);

  function automatic logic [ROW_W-1:0] ring_row(input logic [ROW_W-1:0] base,
                                                input logic [ROW_W-1:0] ofs);
    logic [ROW_W:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (int'(s) >= ROWS) begin
      s = s - (ROW_W+1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  logic [CELL_W-1:0] scr_mem [ROWS*COLUMNS];
  logic [CELL_W-1:0] his_mem [HISTORY_LINES*COLUMNS];

  // latched operation
  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [CNT_W-1:0]  n_r;
  logic [CROW_W-1:0] crow_r;
  logic [CCOL_W-1:0] ccol_r;

  logic [ROW_W-1:0]  row_r, row_nxt, top_r, top_nxt;
  logic [COL_W-1:0]  col_r, col_nxt, target_r, target_nxt;
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic [OFF_W-1:0]  fill_r, fill_nxt, back_r, back_nxt;
  logic [ATTR_W-1:0] tattr_r, battr_r;
  logic [SCR_AW-1:0] sweep_r, sweep_nxt;

  rd_src_t           rd_src_r, rd_src_nxt;
  logic [ROW_W-1:0]  rd_row_r, rd_row_nxt;
  logic [HEAD_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [COL_W-1:0]  rd_col_r;
  logic [CELL_W-1:0] cell_r;

  logic [CELL_W-1:0] scr_q_r, his_q_r;
  logic [SCR_AW-1:0] scr_raddr, scr_waddr;
  logic [HIS_AW-1:0] his_raddr, his_waddr;
  logic [CELL_W-1:0] scr_wdata, blank_cell;
  logic              scr_we, his_we;

  logic [ROW_W-1:0]  cur_phys;
  logic [SCR_AW-1:0] cur_addr;
  logic [COL_W:0]    tab_sum;
  logic [SUM_W-1:0]  up_sum, rw, bw, age, slot_w;
  logic              cmt_wr;

  assign blank_cell = {battr_r, CH_SPACE};
  assign cur_phys   = ring_row(top_r, row_r);
  assign cur_addr   = SCR_AW'(int'(cur_phys) * COLUMNS + int'(col_r));
  assign cmt_wr     = cmd.cmt_step && (sweep_r != '0);

  // status to the sequencer
  always_comb begin
    sts.op = op_r;
    if (ch_r == CH_LF) begin
      sts.cls = CC_LF;
    end else if (ch_r == CH_CR) begin
      sts.cls = CC_CR;
    end else if (ch_r == CH_BS) begin
      sts.cls = CC_BS;
    end else if (ch_r == CH_TAB) begin
      sts.cls = CC_TAB;
    end else if (ch_r >= CH_SPACE) begin
      sts.cls = CC_PRINT;
    end else begin
      sts.cls = CC_IGNORE;
    end
    sts.tab_more = (col_r < target_r);
    sts.wrap     = (int'(col_r) + 1 >= COLUMNS);
    sts.last_row = (int'(row_r) == ROWS - 1);
    sts.cmt_last = (int'(sweep_r) == COLUMNS);
    sts.clr_last = (int'(sweep_r) == ROWS * COLUMNS - 1);
  end

  // memory ports
  always_comb begin
    if (cmd.cmt_step) begin
      scr_raddr = SCR_AW'(int'(top_r) * COLUMNS + int'(sweep_r));
    end else begin
      scr_raddr = SCR_AW'(int'(rd_row_r) * COLUMNS + int'(rd_col_r));
    end
    his_raddr = HIS_AW'(int'(rd_slot_r) * COLUMNS + int'(rd_col_r));
    his_waddr = HIS_AW'(int'(head_r) * COLUMNS + int'(sweep_r) - 1);
    his_we    = cmt_wr;
    scr_we    = 1'b0;
    scr_waddr = cur_addr;
    scr_wdata = blank_cell;
    if (cmd.clr_step) begin
      scr_we    = 1'b1;
      scr_waddr = sweep_r;
      scr_wdata = cmd.init ? CELL_RESET : blank_cell;
    end else if (cmd.tab_wr) begin
      scr_we    = 1'b1;
      scr_wdata = {tattr_r, CH_SPACE};
    end else if (cmd.put_wr) begin
      scr_we    = 1'b1;
      scr_wdata = {tattr_r, ch_r};
    end else if (cmt_wr) begin
      // blank the committed line as it is copied out
      scr_we    = 1'b1;
      scr_waddr = SCR_AW'(int'(top_r) * COLUMNS + int'(sweep_r) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    scr_q_r <= scr_mem[scr_raddr];
  end

  always_ff @(posedge clk) begin
    if (his_we) begin
      his_mem[his_waddr] <= scr_q_r;
    end
    his_q_r <= his_mem[his_raddr];
  end

  // next state
  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    top_nxt     = top_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    back_nxt    = back_r;
    target_nxt  = target_r;
    sweep_nxt   = sweep_r;
    rd_src_nxt  = rd_src_r;
    rd_row_nxt  = rd_row_r;
    rd_slot_nxt = rd_slot_r;
    tab_sum     = (COL_W+1)'(col_r) + (COL_W+1)'(8);
    tab_sum     = tab_sum & ~(COL_W+1)'(7);
    up_sum      = SUM_W'(back_r) + SUM_W'(n_r);
    rw          = SUM_W'(crow_r);
    bw          = SUM_W'(back_r);
    age         = bw - rw;
    slot_w      = SUM_W'(head_r) + SUM_W'(HISTORY_LINES) - age;
    if (int'(slot_w) >= HISTORY_LINES) begin
      slot_w = slot_w - SUM_W'(HISTORY_LINES);
    end

    if (cmd.cap) begin
      sweep_nxt = '0;
    end
    if (cmd.exec) begin
      case (op_r)
        OP_PUT: begin
          back_nxt = '0;
          if (ch_r == CH_LF || ch_r == CH_CR) begin
            col_nxt = '0;
          end else if (ch_r == CH_BS && col_r != '0) begin
            col_nxt = col_r - COL_W'(1);
          end
          if (int'(tab_sum) >= COLUMNS) begin
            target_nxt = COL_W'(COLUMNS - 1);
          end else begin
            target_nxt = tab_sum[COL_W-1:0];
          end
        end
        OP_UP: begin
          back_nxt = (up_sum > SUM_W'(fill_r)) ? fill_r : up_sum[OFF_W-1:0];
        end
        OP_DOWN: begin
          back_nxt = (SUM_W'(n_r) >= bw) ? '0 : OFF_W'(bw - SUM_W'(n_r));
        end
        OP_READ: begin
          if (int'(crow_r) >= ROWS || int'(ccol_r) >= COLUMNS) begin
            rd_src_nxt = RS_ZERO;
          end else if (rw >= bw) begin
            rd_src_nxt = RS_SCREEN;
            rd_row_nxt = ring_row(top_r, ROW_W'(rw - bw));
          end else if (age > SUM_W'(fill_r)) begin
            rd_src_nxt = RS_BLANK;
          end else begin
            rd_src_nxt  = RS_HIST;
            rd_slot_nxt = slot_w[HEAD_W-1:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd.tab_wr) begin
      col_nxt = col_r + COL_W'(1);
    end
    if (cmd.put_wr) begin
      col_nxt = sts.wrap ? '0 : col_r + COL_W'(1);
    end
    if (cmd.adv) begin
      row_nxt = row_r + ROW_W'(1);
    end
    if (cmd.cmt_step || cmd.clr_step) begin
      sweep_nxt = sweep_r + SCR_AW'(1);
    end
    if (cmd.cmt_end) begin
      // the blanked old top line becomes the bottom line
      top_nxt  = ring_row(top_r, ROW_W'(1));
      head_nxt = (int'(head_r) == HISTORY_LINES - 1) ? '0 : head_r + HEAD_W'(1);
      if (int'(fill_r) < HISTORY_LINES) begin
        fill_nxt = fill_r + OFF_W'(1);
      end
    end
    if (cmd.clr_end) begin
      row_nxt   = '0;
      col_nxt   = '0;
      back_nxt  = '0;
      sweep_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      top_r    <= '0;
      head_r   <= '0;
      fill_r   <= '0;
      back_r   <= '0;
      sweep_r  <= '0;
      tattr_r  <= ATTR_RESET;
      battr_r  <= ATTR_RESET;
    end else begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      top_r   <= top_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      back_r  <= back_nxt;
      sweep_r <= sweep_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEXT_ATTR:  tattr_r <= cfg_data;
          CFG_BLANK_ATTR: battr_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    target_r  <= target_nxt;
    rd_src_r  <= rd_src_nxt;
    rd_row_r  <= rd_row_nxt;
    rd_slot_r <= rd_slot_nxt;
    if (cmd.cap) begin
      op_r     <= in_operation;
      ch_r     <= in_char_code;
      n_r      <= in_line_count;
      crow_r   <= in_cell_row;
      ccol_r   <= in_cell_column;
      rd_col_r <= COL_W'(in_cell_column);
      cell_r   <= '0;
    end
    if (cmd.rd_take) begin
      case (rd_src_r)
        RS_BLANK:  cell_r <= blank_cell;
        RS_SCREEN: cell_r <= scr_q_r;
        RS_HIST:   cell_r <= his_q_r;
        default:   cell_r <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_cursor_row    <= CROW_W'(row_r);
      out_cursor_column <= CCOL_W'(col_r);
      out_view_offset   <= VOFF_W'(back_r);
      out_cursor_shown  <= (back_r == '0);
      out_cell_data     <= cell_r;
    end
  end

endmodule

[hdl/text_console_writer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console with live screen, cursor and scroll-back history ring.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake       | beat
//  in_ch    | in        | valid/ready     | operation, char, count, row, column
//  out_ch   | out       | valid/ready     | cursor, view offset, shown, cell
//  cfg_*    | in        | write enable    | attribute registers, no read-back
//
// One operation at a time. Scroll, carriage return, backspace and ignored codes
// go from the accept and execute steps straight to the result load; a printable
// character adds a write, a newline an advance, a read an issue and a take step,
// and a tab one write per space. A line commit walks one screen row, and clear
// walks the whole screen memory. After reset a clearing pass runs before in_ch
// goes ready. A waiting result is held while the next beat is taken.
// ----------------------------------------------------------------------------
module text_console_writer_core import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_in_if.sink                in_ch,
  tcw_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_ch.operation),
    .in_char_code      (in_ch.char_code),
    .in_line_count     (in_ch.line_count),
    .in_cell_row       (in_ch.cell_row),
    .in_cell_column    (in_ch.cell_column),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_cursor_row    (out_ch.cursor_row),
    .out_cursor_column (out_ch.cursor_column),
    .out_view_offset   (out_ch.view_offset),
    .out_cursor_shown  (out_ch.cursor_shown),
    .out_cell_data     (out_ch.cell_data)
  );

endmodule
